>>> sv/pe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pe_pkg
// Shared types, constants and rounding helpers of the polynomial evaluator.
// ----------------------------------------------------------------------------
package pe_pkg;

   localparam int COEF_REGS  = 8;
   localparam int CSR_AW     = 5;
   localparam int X_W        = 16;
   localparam int Q_W        = 32;
   localparam int WIDE_W     = 48;

   localparam logic [Q_W-1:0]           Q16_ONE = 32'h0001_0000;
   localparam logic signed [WIDE_W-1:0] S32_MAX = 48'sh0000_7FFF_FFFF;
   localparam logic signed [WIDE_W-1:0] S32_MIN = 48'shFFFF_8000_0000;

   typedef struct packed {
      logic [Q_W-1:0] value;
      logic           ovf;
   } sat_type;

   typedef struct packed {
      logic           valid;
      logic [X_W-1:0] x;
      logic [Q_W-1:0] power;
      logic [Q_W-1:0] acc;
      logic           ovf;
   } link_type;

   function automatic sat_type sat48(input logic signed [WIDE_W-1:0] v);
      sat_type r;
      if (v > S32_MAX) begin
         r.value = S32_MAX[Q_W-1:0];
         r.ovf   = 1'b1;
      end else if (v < S32_MIN) begin
         r.value = S32_MIN[Q_W-1:0];
         r.ovf   = 1'b1;
      end else begin
         r.value = v[Q_W-1:0];
         r.ovf   = 1'b0;
      end
      return r;
   endfunction

   // Q.28 power product back to Q15.16, round half up
   function automatic sat_type rnd_sat_px(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] r;
      r = v + 48'sd2048;
      return sat48(r >>> 12);
   endfunction

   // Q.32 term product back to Q15.16, round half up
   function automatic sat_type rnd_sat_cp(input logic signed [63:0] v);
      logic signed [63:0] r;
      logic signed [63:0] s;
      r = v + 64'sd32768;
      s = r >>> 16;
      return sat48(WIDE_W'(s));
   endfunction

endpackage
`default_nettype wire

>>> sv/pe_csr.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pe_csr
// APB-style coefficient register file, eight signed Q15.16 coefficients.
// ----------------------------------------------------------------------------
module pe_csr
   import pe_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [CSR_AW-1:0] paddr,
   input  wire logic [Q_W-1:0]    pwdata,
   output logic [Q_W-1:0]         prdata,
   output logic                   pready,
   output logic [Q_W-1:0]         coef [COEF_REGS]
);

   logic [Q_W-1:0] coef_ff [COEF_REGS];
   logic [2:0]     index;

   assign index  = paddr[CSR_AW-1:2];
   assign pready = 1'b1;
   assign prdata = coef_ff[index];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < COEF_REGS; i++) coef_ff[i] <= '0;
      end else if (psel && penable && pwrite) begin
         coef_ff[index] <= pwdata;
      end
   end

   always_comb begin
      for (int i = 0; i < COEF_REGS; i++) coef[i] = coef_ff[i];
   end

endmodule
`default_nettype wire

>>> sv/pe_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pe_cell
// One term of the power form: advance the power by x, scale by the
// coefficient and add into the running sum, over four register stages.
// ----------------------------------------------------------------------------
module pe_cell
   import pe_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic [Q_W-1:0] coef,
   input  wire link_type       link_in,
   output link_type            link_out
);

   typedef struct packed {
      logic              valid;
      logic [X_W-1:0]    x;
      logic [Q_W-1:0]    acc;
      logic              ovf;
      logic [WIDE_W-1:0] prod;
   } px_type;

   typedef struct packed {
      logic              valid;
      logic [X_W-1:0]    x;
      logic [Q_W-1:0]    power;
      logic [Q_W-1:0]    acc;
      logic              ovf;
      logic [63:0]       prod;
   } cp_type;

   px_type   s1_ff, s1_in;
   link_type s2_ff, s2_in;
   cp_type   s3_ff, s3_in;
   link_type s4_ff, s4_in;
   sat_type  pw_sat, term_sat, sum_sat;

   always_comb begin
      s1_in.valid = link_in.valid;
      s1_in.x     = link_in.x;
      s1_in.acc   = link_in.acc;
      s1_in.ovf   = link_in.ovf;
      s1_in.prod  = WIDE_W'($signed(link_in.power)) * WIDE_W'($signed(link_in.x));
   end

   always_comb begin
      pw_sat      = rnd_sat_px($signed(s1_ff.prod));
      s2_in.valid = s1_ff.valid;
      s2_in.x     = s1_ff.x;
      s2_in.power = pw_sat.value;
      s2_in.acc   = s1_ff.acc;
      s2_in.ovf   = s1_ff.ovf | pw_sat.ovf;
   end

   always_comb begin
      s3_in.valid = s2_ff.valid;
      s3_in.x     = s2_ff.x;
      s3_in.power = s2_ff.power;
      s3_in.acc   = s2_ff.acc;
      s3_in.ovf   = s2_ff.ovf;
      s3_in.prod  = 64'($signed(coef)) * 64'($signed(s2_ff.power));
   end

   always_comb begin
      term_sat    = rnd_sat_cp($signed(s3_ff.prod));
      sum_sat     = sat48(WIDE_W'($signed(s3_ff.acc)) + WIDE_W'($signed(term_sat.value)));
      s4_in.valid = s3_ff.valid;
      s4_in.x     = s3_ff.x;
      s4_in.power = s3_ff.power;
      s4_in.acc   = sum_sat.value;
      s4_in.ovf   = s3_ff.ovf | term_sat.ovf | sum_sat.ovf;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
         s2_ff.valid <= 1'b0;
         s3_ff.valid <= 1'b0;
         s4_ff.valid <= 1'b0;
      end else begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
      end
   end

   assign link_out = s4_ff;

endmodule
`default_nettype wire

>>> sv/polynomial_evaluator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// polynomial_evaluator
// Power-form polynomial of a Q3.12 sample with Q15.16 coefficients.
// ----------------------------------------------------------------------------
// Usage:
//   Coefficients coef_0 .. coef_7 sit at byte addresses 0x00 .. 0x1C of the
//   APB-style port; write them while no request is in flight. A request is
//   taken at each clock edge with start high and busy low; busy stays low,
//   so a new sample may enter every cycle.
//   The result shows on rsp_poly_value and rsp_overflow with rsp_valid high
//   for one cycle. It passes through the chain of NUM_COEFFS-1 term cells,
//   each with four register stages (power product, power rounding, term
//   product, rounding and accumulate); results leave in request order.
//   The receiver cannot stall: rsp_valid is a strobe and is not held.
//   Reset clears all coefficients to zero and drops requests in flight.
// ----------------------------------------------------------------------------
module polynomial_evaluator
   import pe_pkg::*;
#(
   parameter int NUM_COEFFS = 8
)
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [CSR_AW-1:0] paddr,
   input  wire logic [Q_W-1:0]    pwdata,
   output logic [Q_W-1:0]         prdata,
   output logic                   pready,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [X_W-1:0]    req_x_value,
   output logic                   rsp_valid,
   output logic [Q_W-1:0]         rsp_poly_value,
   output logic                   rsp_overflow
);

   logic [Q_W-1:0] coef [COEF_REGS];
   link_type       link [NUM_COEFFS];

   pe_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .coef    (coef)
   );

   assign busy = 1'b0;

   always_comb begin
      link[0].valid = start && !busy;
      link[0].x     = req_x_value;
      link[0].power = Q16_ONE;
      link[0].acc   = coef[0];
      link[0].ovf   = 1'b0;
   end

   for (genvar g = 1; g < NUM_COEFFS; g++) begin : g_cell
      pe_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .coef     (coef[g]),
         .link_in  (link[g-1]),
         .link_out (link[g])
      );
   end

   assign rsp_valid      = link[NUM_COEFFS-1].valid;
   assign rsp_poly_value = link[NUM_COEFFS-1].acc;
   assign rsp_overflow   = link[NUM_COEFFS-1].ovf;

endmodule
`default_nettype wire

>>> sv/pe_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pe_checker
// Port-level checks of the polynomial evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module pe_checker
   import pe_pkg::*;
#(
   parameter int NUM_COEFFS = 8
)
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              psel,
   input wire logic              penable,
   input wire logic              pwrite,
   input wire logic [CSR_AW-1:0] paddr,
   input wire logic [Q_W-1:0]    pwdata,
   input wire logic [Q_W-1:0]    prdata,
   input wire logic              pready,
   input wire logic              start,
   input wire logic              busy,
   input wire logic              rsp_valid
);

   localparam int LAT = 4 * (NUM_COEFFS - 1);

   a_rsp_has_request: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LAT))
      else $error("response without a matching request");

   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      (psel && penable && pwrite) ##1 (psel && !pwrite && paddr == $past(paddr))
      |-> prdata == $past(pwdata))
      else $error("coefficient readback mismatch");

   a_pready_high: assert property (@(posedge clock) disable iff (reset) pready)
      else $error("pready low");

   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

endmodule

bind polynomial_evaluator pe_checker #(.NUM_COEFFS(NUM_COEFFS)) u_pe_checker (
   .clock     (clock),
   .reset     (reset),
   .psel      (psel),
   .penable   (penable),
   .pwrite    (pwrite),
   .paddr     (paddr),
   .pwdata    (pwdata),
   .prdata    (prdata),
   .pready    (pready),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);
`default_nettype wire
